>>> hw/rtl/maze_path_search_defines.svh
// Assertion macros shared by the maze search RTL.
// No dependencies.
`ifndef MAZE_PATH_SEARCH_DEFINES_SVH
`define MAZE_PATH_SEARCH_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MPS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define MPS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mps_pkg.sv
// Shared types and constants for the maze search block.
// No dependencies.
package mps_pkg;

  localparam int MAX_SIDE_DEF = 32;
  localparam logic [5:0] SIZE_RESET = 6'd24;

  localparam logic [1:0] ST_AVAIL = 2'd0;
  localparam logic [1:0] ST_ROUTE = 2'd1;
  localparam logic [1:0] ST_BACK  = 2'd2;
  localparam logic [1:0] ST_WALL  = 2'd3;

  localparam logic [2:0] D_NONE  = 3'd0;
  localparam logic [2:0] D_EAST  = 3'd1;
  localparam logic [2:0] D_SOUTH = 3'd2;
  localparam logic [2:0] D_WEST  = 3'd3;
  localparam logic [2:0] D_NORTH = 3'd4;
  localparam logic [2:0] D_NOWAY = 3'd5;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_SOLVE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_ROUTE = 2'd3;

  localparam logic [2:0] RC_DONE    = 3'd0;
  localparam logic [2:0] RC_FOUND   = 3'd1;
  localparam logic [2:0] RC_NOROUTE = 3'd2;
  localparam logic [2:0] RC_BLOCKED = 3'd3;
  localparam logic [2:0] RC_RANGE   = 3'd4;

  localparam logic [2:0] CFG_SIZE    = 3'd0;
  localparam logic [2:0] CFG_START_X = 3'd1;
  localparam logic [2:0] CFG_START_Y = 3'd2;
  localparam logic [2:0] CFG_GOAL_X  = 3'd3;
  localparam logic [2:0] CFG_GOAL_Y  = 3'd4;

  // Direction to step back into the cell we came from.
  function automatic logic [2:0] back_dir(input logic [2:0] d);
    case (d)
      D_EAST:  back_dir = D_WEST;
      D_SOUTH: back_dir = D_NORTH;
      D_WEST:  back_dir = D_EAST;
      D_NORTH: back_dir = D_SOUTH;
      default: back_dir = D_NONE;
    endcase
  endfunction

endpackage

>>> hw/rtl/maze_path_search.sv
// Maze search block: command sequencer, cell store and route stack.
// Depends on mps_pkg and maze_path_search_defines.svh.
//
// Each command takes one input transfer and gives one result transfer. After
// reset the cell store is cleared to wall, all MAX_SIDE*MAX_SIDE (1024) cells,
// before the first item is taken. The largest grid side is the package constant
// MAX_SIDE_DEF; the side in use is the configured size clamped to it. A new item
// is taken only in the idle state, after the last result has been taken. A cell
// write or an out-of-range route read gives its result from the idle state; a
// cell read goes through the report states, and a route read first reads the
// route stack. A solve checks the start and goal cells, searches, then reports.
// The single-port cell store is read once per direction tried; entering a cell
// writes it once more, and popping a dead end reads the stack top, then the cell.
`include "maze_path_search_defines.svh"
module maze_path_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [4:0]  cell_x,
  input  logic [4:0]  cell_y,
  input  logic        open,
  input  logic [9:0]  route_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  code,
  output logic [10:0] route_length,
  output logic [4:0]  out_x,
  output logic [4:0]  out_y,
  output logic [1:0]  cell_state,
  output logic [2:0]  came_from,
  output logic [2:0]  went_to
);
  import mps_pkg::*;

  localparam int MAX_SIDE = MAX_SIDE_DEF;
  localparam int CW = $clog2(MAX_SIDE);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW = 2 * CW;
  localparam int DW = AW + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_RDW, S_CHK, S_STEP, S_PROBE, S_PROBEW,
    S_PUSH, S_MARK_NEXT, S_TOP, S_TOPW, S_POPRD, S_POPW, S_POPE,
    S_REPORT, S_REPW, S_REPD, S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [5:0] maze_size;
  logic [4:0] start_x, start_y, goal_x, goal_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      maze_size <= SIZE_RESET;
      start_x <= 5'd1;
      start_y <= 5'd1;
      goal_x <= 5'd1;
      goal_y <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE:    maze_size <= cfg_data;
        CFG_START_X: start_x <= cfg_data[4:0];
        CFG_START_Y: start_y <= cfg_data[4:0];
        CFG_GOAL_X:  goal_x <= cfg_data[4:0];
        CFG_GOAL_Y:  goal_y <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Grid side in use, clamped to MAX_SIDE
  logic [6:0] side;
  assign side = ({1'b0, maze_size} > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : {1'b0, maze_size};

  // Cell store and route stack
  logic [7:0]    cmem [CELLS];
  logic [AW-1:0] smem [CELLS];
  logic [7:0]    crd;
  logic [AW-1:0] srd;
  logic          c_we;
  logic [AW-1:0] c_addr;
  logic [7:0]    c_wd;
  logic          s_we;
  logic [AW-1:0] s_addr;
  logic [AW-1:0] s_wd;

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_addr] <= c_wd;
    crd <= cmem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_addr] <= s_wd;
    srd <= smem[s_addr];
  end

  // Working registers
  logic [1:0]    act;
  logic [9:0]    iri;
  logic [DW-1:0] depth;
  logic [AW-1:0] cur;
  logic [7:0]    cur_e;
  logic [2:0]    dir;
  logic [AW-1:0] caddr;
  logic [4:0]    rx, ry;
  logic          rin;
  logic [2:0]    rcode;
  logic [AW-1:0] clr_cnt;
  logic          chk_goal;
  logic          store_we;
  logic [AW-1:0] store_a;
  logic [7:0]    store_d;

  function automatic logic [AW-1:0] mk_addr(input logic [4:0] x, input logic [4:0] y);
    mk_addr = {x[CW-1:0], y[CW-1:0]};
  endfunction

  function automatic logic in_grid(input logic [6:0] x, input logic [6:0] y,
                                   input logic [6:0] s);
    in_grid = (x < s) && (y < s);
  endfunction

  // Current cell coordinates and probed neighbour
  logic [6:0] cxw, cyw, nx, ny;
  logic       n_in;
  assign cxw = 7'(cur[AW-1:CW]);
  assign cyw = 7'(cur[CW-1:0]);
  always_comb begin
    nx = cxw;
    ny = cyw;
    case (dir)
      D_EAST:  nx = cxw + 7'd1;
      D_SOUTH: ny = cyw + 7'd1;
      D_WEST:  nx = cxw - 7'd1;
      D_NORTH: ny = cyw - 7'd1;
      default: ;
    endcase
  end
  assign n_in = in_grid(nx, ny, side);

  // Memory port steering; hold the read address through each wait state
  always_comb begin
    c_we = store_we;
    c_addr = store_a;
    c_wd = store_d;
    s_we = 1'b0;
    s_addr = depth[AW-1:0] - AW'(1);
    s_wd = cur;
    case (state)
      S_CLEAR: begin
        c_we = 1'b1;
        c_addr = clr_cnt;
        c_wd = {D_NONE, D_NONE, ST_WALL};
      end
      S_PROBE, S_PROBEW: c_addr = {nx[CW-1:0], ny[CW-1:0]};
      S_RD, S_RDW, S_REPW, S_POPRD, S_POPW: c_addr = caddr;
      S_IDLE: s_addr = route_index[AW-1:0];
      S_CHK: begin
        s_we = 1'b1;
        s_addr = '0;
        s_wd = mk_addr(start_x, start_y);
      end
      S_TOP: s_addr = depth[AW-1:0] - AW'(1);
      S_PUSH: begin
        s_we = 1'b1;
        s_addr = depth[AW-1:0];
        s_wd = {nx[CW-1:0], ny[CW-1:0]};
      end
      default: s_addr = iri[AW-1:0];
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      depth <= '0;
      out_valid <= 1'b0;
      store_we <= 1'b0;
    end else begin
      store_we <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            act <= action;
            iri <= route_index;
            case (action)
              ACT_WRITE: begin
                if (32'(cell_x) < 32'(MAX_SIDE) && 32'(cell_y) < 32'(MAX_SIDE)) begin
                  store_we <= 1'b1;
                  store_a <= mk_addr(cell_x, cell_y);
                  store_d <= {D_NONE, D_NONE, open ? ST_AVAIL : ST_WALL};
                end
                state <= S_OUT;
                rcode <= RC_DONE;
                rx <= cell_x;
                ry <= cell_y;
                rin <= 1'b1;
                code <= RC_DONE;
                out_x <= cell_x;
                out_y <= cell_y;
                cell_state <= open ? ST_AVAIL : ST_WALL;
                came_from <= D_NONE;
                went_to <= D_NONE;
                route_length <= 11'(depth);
                out_valid <= 1'b1;
              end
              ACT_SOLVE: begin
                depth <= '0;
                caddr <= mk_addr(start_x, start_y);
                chk_goal <= 1'b0;
                state <= S_RD;
              end
              ACT_READ: begin
                rcode <= RC_DONE;
                rx <= cell_x;
                ry <= cell_y;
                rin <= in_grid(7'(cell_x), 7'(cell_y), side);
                caddr <= mk_addr(cell_x, cell_y);
                state <= S_REPORT;
              end
              default: begin
                if (DW'(route_index) < depth) begin
                  state <= S_TOPW;
                end else begin
                  code <= RC_RANGE;
                  out_x <= '0;
                  out_y <= '0;
                  cell_state <= ST_AVAIL;
                  came_from <= D_NONE;
                  went_to <= D_NONE;
                  route_length <= 11'(depth);
                  out_valid <= 1'b1;
                  state <= S_OUT;
                end
              end
            endcase
          end
        end
        // Check start then goal availability
        S_RD: state <= S_RDW;
        S_RDW: state <= S_CHK;
        S_CHK: begin
          if (!chk_goal) begin
            if (!in_grid(7'(start_x), 7'(start_y), side) || crd[1:0] != ST_AVAIL) begin
              rcode <= RC_BLOCKED;
              state <= S_REPORT;
              caddr <= mk_addr(goal_x, goal_y);
            end else begin
              cur_e <= crd;
              chk_goal <= 1'b1;
              caddr <= mk_addr(goal_x, goal_y);
              state <= S_RD;
            end
          end else begin
            if (!in_grid(7'(goal_x), 7'(goal_y), side) || crd[1:0] != ST_AVAIL) begin
              rcode <= RC_BLOCKED;
              state <= S_REPORT;
            end else begin
              // Push start
              cur <= mk_addr(start_x, start_y);
              store_we <= 1'b1;
              store_a <= mk_addr(start_x, start_y);
              store_d <= {cur_e[7:5], D_NONE, ST_ROUTE};
              cur_e <= {cur_e[7:5], D_NONE, ST_ROUTE};
              dir <= cur_e[7:5];
              depth <= DW'(1);
              state <= S_STEP;
            end
          end
        end
        // Decide on the current top cell
        S_STEP: begin
          if (cur == mk_addr(goal_x, goal_y) && 5'(cxw) == goal_x && 5'(cyw) == goal_y) begin
            rcode <= RC_FOUND;
            state <= S_REPORT;
          end else if (dir >= D_NOWAY || dir == D_NORTH) begin
            store_we <= 1'b1;
            store_a <= cur;
            store_d <= {D_NOWAY, cur_e[4:2], ST_BACK};
            depth <= depth - DW'(1);
            state <= S_TOP;
            if (depth == DW'(1)) begin
              rcode <= RC_NOROUTE;
              state <= S_REPORT;
            end
          end else begin
            dir <= dir + 3'd1;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          state <= n_in ? S_PROBEW : S_STEP;
        end
        S_PROBEW: state <= S_PUSH;
        S_PUSH: begin
          if (crd[1:0] == ST_AVAIL) begin
            // Record exit, enter neighbour
            store_we <= 1'b1;
            store_a <= cur;
            store_d <= {dir, cur_e[4:2], cur_e[1:0]};
            depth <= depth + DW'(1);
            cur <= {nx[CW-1:0], ny[CW-1:0]};
            cur_e <= {D_NONE, back_dir(dir), ST_ROUTE};
            dir <= D_NONE;
            state <= S_MARK_NEXT;
          end else begin
            state <= S_STEP;
          end
        end
        S_TOP: state <= S_TOPW;
        S_TOPW: begin
          if (act == ACT_ROUTE) begin
            rcode <= RC_DONE;
            rx <= 5'(srd[AW-1:CW]);
            ry <= 5'(srd[CW-1:0]);
            rin <= in_grid(7'(srd[AW-1:CW]), 7'(srd[CW-1:0]), side);
            caddr <= srd;
            state <= S_REPORT;
          end else begin
            cur <= srd;
            caddr <= srd;
            state <= S_POPRD;
          end
        end
        S_POPRD: state <= S_POPW;
        S_POPW: state <= S_POPE;
        S_POPE: begin
          cur_e <= crd;
          dir <= crd[7:5];
          state <= S_STEP;
        end
        S_MARK_NEXT: begin
          store_we <= 1'b1;
          store_a <= cur;
          store_d <= cur_e;
          if (depth >= DW'(CELLS) && !(5'(cxw) == goal_x && 5'(cyw) == goal_y)) begin
            rcode <= RC_NOROUTE;
            state <= S_REPORT;
          end else begin
            state <= S_STEP;
          end
        end
        // Read reported cell and drive result
        S_REPORT: begin
          if (act == ACT_SOLVE) begin
            rx <= goal_x;
            ry <= goal_y;
            rin <= in_grid(7'(goal_x), 7'(goal_y), side);
            caddr <= mk_addr(goal_x, goal_y);
            if (rcode != RC_FOUND) depth <= '0;
          end
          state <= S_REPW;
        end
        S_REPW: state <= S_REPD;
        S_REPD: begin
          code <= rcode;
          out_x <= rx;
          out_y <= ry;
          cell_state <= rin ? crd[1:0] : ST_WALL;
          came_from <= rin ? crd[4:2] : D_NONE;
          went_to <= rin ? crd[7:5] : D_NONE;
          route_length <= 11'(depth);
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MPS_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall, "accepted while busy")
  `MPS_ASSERT_IMPL(a_depth_bound, clk, rst, 1'b1, depth <= DW'(CELLS), "route stack overflow")
  `MPS_ASSERT_NEXT(a_out_done, clk, rst, out_valid && !out_stall, !out_valid, "result repeated")

endmodule

>>> verif/maze_path_search_test.sv
// Self-checking bench for the maze search block: directed and random commands.
// Depends on mps_pkg and the maze_path_search RTL; predicts every result itself.
`timescale 1ns / 1ps
module maze_path_search_test;
  import mps_pkg::*;

  localparam int GRID = 32;
  localparam int CELLS = GRID * GRID;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [2:0]  code;
    logic [10:0] route_length;
    logic [4:0]  out_x;
    logic [4:0]  out_y;
    logic [1:0]  cell_state;
    logic [2:0]  came_from;
    logic [2:0]  went_to;
  } maze_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_SIZE;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_READ;
  logic [4:0]  cell_x = '0;
  logic [4:0]  cell_y = '0;
  logic        open = 1'b0;
  logic [9:0]  route_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  code;
  logic [10:0] route_length;
  logic [4:0]  out_x;
  logic [4:0]  out_y;
  logic [1:0]  cell_state;
  logic [2:0]  came_from;
  logic [2:0]  went_to;

  // Predicted block state
  logic [7:0]   grid_mem [CELLS];
  logic [9:0]   path_mem [CELLS];
  int           path_depth;
  int           size_reg, start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;
  maze_result_t pending_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  maze_path_search i_dut (.*);

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("maze_path_search_test: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] pack_cell(logic [1:0] st, logic [2:0] cf, logic [2:0] wt);
    return {wt, cf, st};
  endfunction

  function automatic int grid_side();
    return (size_reg > GRID) ? GRID : size_reg;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < grid_side() && y < grid_side();
  endfunction

  function automatic int cell_addr(int x, int y);
    return (x * GRID + y) % CELLS;
  endfunction

  function automatic logic [1:0] status_of(int x, int y);
    if (!on_grid(x, y)) return ST_WALL;
    return grid_mem[cell_addr(x, y)][1:0];
  endfunction

  function automatic void report_cell(int x, int y, inout maze_result_t r);
    logic [7:0] c;
    r.out_x = x[4:0];
    r.out_y = y[4:0];
    if (!on_grid(x, y)) begin
      r.cell_state = ST_WALL;
      r.came_from = D_NONE;
      r.went_to = D_NONE;
    end else begin
      c = grid_mem[cell_addr(x, y)];
      r.cell_state = c[1:0];
      r.came_from = c[4:2];
      r.went_to = c[7:5];
    end
  endfunction

  // Depth-first walk: east, south, west, north; pop dead ends as backtracked
  function automatic logic [2:0] search_route();
    int cur, x, y, nx, ny, d, na;
    logic [7:0] e;
    logic [2:0] back;
    path_depth = 0;
    if (status_of(start_x_reg, start_y_reg) != ST_AVAIL ||
        status_of(goal_x_reg, goal_y_reg) != ST_AVAIL) return RC_BLOCKED;
    cur = cell_addr(start_x_reg, start_y_reg);
    grid_mem[cur] = pack_cell(ST_ROUTE, D_NONE, grid_mem[cur][7:5]);
    path_mem[0] = cur[9:0];
    path_depth = 1;
    while (path_depth > 0) begin
      cur = path_mem[path_depth - 1];
      x = cur / GRID;
      y = cur % GRID;
      if (x == goal_x_reg && y == goal_y_reg) return RC_FOUND;
      e = grid_mem[cur];
      d = e[7:5];
      nx = x;
      ny = y;
      while (d < D_NOWAY) begin
        d++;
        nx = x;
        ny = y;
        if (d == D_EAST) nx = x + 1;
        else if (d == D_SOUTH) ny = y + 1;
        else if (d == D_WEST) nx = x - 1;
        else if (d == D_NORTH) ny = y - 1;
        else break;
        if (status_of(nx, ny) == ST_AVAIL) break;
      end
      if (d >= D_NOWAY) begin
        grid_mem[cur] = pack_cell(ST_BACK, e[4:2], D_NOWAY);
        path_depth--;
      end else begin
        case (d)
          D_EAST:  back = D_WEST;
          D_SOUTH: back = D_NORTH;
          D_WEST:  back = D_EAST;
          default: back = D_SOUTH;
        endcase
        grid_mem[cur] = pack_cell(e[1:0], e[4:2], d[2:0]);
        na = cell_addr(nx, ny);
        grid_mem[na] = pack_cell(ST_ROUTE, back, D_NONE);
        if (path_depth >= CELLS) return RC_NOROUTE;
        path_mem[path_depth] = na[9:0];
        path_depth++;
      end
    end
    return RC_NOROUTE;
  endfunction

  function automatic maze_result_t predict_result(logic [1:0] act, int x, int y, bit op, int ri);
    maze_result_t r;
    logic [1:0] st;
    int a;
    r = '0;
    case (act)
      ACT_WRITE: begin
        st = op ? ST_AVAIL : ST_WALL;
        grid_mem[cell_addr(x, y)] = pack_cell(st, D_NONE, D_NONE);
        r.out_x = x[4:0];
        r.out_y = y[4:0];
        r.cell_state = st;
      end
      ACT_SOLVE: begin
        r.code = search_route();
        report_cell(goal_x_reg, goal_y_reg, r);
      end
      ACT_READ: report_cell(x, y, r);
      default: begin
        if (ri < path_depth) begin
          a = path_mem[ri];
          report_cell(a / GRID, a % GRID, r);
        end else begin
          r.code = RC_RANGE;
        end
      end
    endcase
    r.route_length = path_depth[10:0];
    return r;
  endfunction

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 16);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    maze_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{code, route_length, out_x, out_y, cell_state, came_from, went_to};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.code != want.code) begin
          $display("%0t: code exp %0d got %0d", $time, want.code, got.code);
          error_count++;
        end
        if (got.route_length != want.route_length) begin
          $display("%0t: route_length exp %0d got %0d", $time, want.route_length,
                   got.route_length);
          error_count++;
        end
        if (got.out_x != want.out_x) begin
          $display("%0t: out_x exp %0d got %0d", $time, want.out_x, got.out_x);
          error_count++;
        end
        if (got.out_y != want.out_y) begin
          $display("%0t: out_y exp %0d got %0d", $time, want.out_y, got.out_y);
          error_count++;
        end
        if (got.cell_state != want.cell_state) begin
          $display("%0t: cell_state exp %0d got %0d", $time, want.cell_state,
                   got.cell_state);
          error_count++;
        end
        if (got.came_from != want.came_from) begin
          $display("%0t: came_from exp %0d got %0d", $time, want.came_from, got.came_from);
          error_count++;
        end
        if (got.went_to != want.went_to) begin
          $display("%0t: went_to exp %0d got %0d", $time, want.went_to, got.went_to);
          error_count++;
        end
      end
    end
  end

  // Offer one command and hold it until the transfer happens
  task automatic send_cmd(logic [1:0] act, int x, int y, bit op, int ri);
    if (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    action <= act;
    cell_x <= x[4:0];
    cell_y <= y[4:0];
    open <= op;
    route_index <= ri[9:0];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(act, x, y, op, ri));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[5:0];
    @(posedge clk);
    case (idx)
      CFG_SIZE:    size_reg = val & 63;
      CFG_START_X: start_x_reg = val & 31;
      CFG_START_Y: start_y_reg = val & 31;
      CFG_GOAL_X:  goal_x_reg = val & 31;
      default:     goal_y_reg = val & 31;
    endcase
  endtask

  task automatic set_maze(int sz, int sx, int sy, int gx, int gy);
    write_reg(CFG_SIZE, sz);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_GOAL_X, gx);
    write_reg(CFG_GOAL_Y, gy);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset settings: blocked start, outside reads, start equal to goal
  task automatic test_reset_defaults();
    send_cmd(ACT_SOLVE, 0, 0, 0, 0);
    send_cmd(ACT_READ, 0, 0, 0, 0);
    send_cmd(ACT_READ, 31, 31, 0, 0);
    send_cmd(ACT_ROUTE, 0, 0, 0, 0);
    send_cmd(ACT_WRITE, 1, 1, 1, 0);
    send_cmd(ACT_SOLVE, 0, 0, 0, 0);
    send_cmd(ACT_ROUTE, 0, 0, 0, 0);
    send_cmd(ACT_ROUTE, 0, 0, 0, 1023);
    send_cmd(ACT_WRITE, 31, 31, 1, 0);
    send_cmd(ACT_READ, 31, 31, 0, 0);
    send_cmd(ACT_WRITE, 1, 1, 0, 0);
    drain();
  endtask

  // Three-by-three grid: route found, repeat solve blocked, then a dead end
  task automatic test_small_grid();
    set_maze(3, 0, 0, 2, 2);
    for (int x = 0; x < 3; x++)
      for (int y = 0; y < 3; y++) send_cmd(ACT_WRITE, x, y, 1, 0);
    send_cmd(ACT_SOLVE, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_cmd(ACT_ROUTE, 0, 0, 0, i);
    send_cmd(ACT_SOLVE, 0, 0, 0, 0);
    for (int x = 0; x < 3; x++)
      for (int y = 0; y < 3; y++)
        send_cmd(ACT_WRITE, x, y, (x + y == 0) || (x + y == 1) || (x + y == 4), 0);
    send_cmd(ACT_SOLVE, 0, 0, 0, 0);
    send_cmd(ACT_READ, 1, 0, 0, 0);
    send_cmd(ACT_READ, 0, 1, 0, 0);
    drain();
  endtask

  // Oversized setting clamps to the full grid; corridor across its corners
  task automatic test_full_grid();
    set_maze(63, 0, 0, 31, 31);
    for (int x = 0; x < 32; x++) send_cmd(ACT_WRITE, x, 0, 1, 0);
    for (int y = 1; y < 32; y++) send_cmd(ACT_WRITE, 31, y, 1, 0);
    send_cmd(ACT_SOLVE, 0, 0, 0, 0);
    send_cmd(ACT_ROUTE, 0, 0, 0, 62);
    send_cmd(ACT_ROUTE, 0, 0, 0, 63);
    send_cmd(ACT_READ, 31, 31, 0, 0);
    send_cmd(ACT_READ, 30, 31, 0, 0);
    drain();
  endtask

  // Hold the output long enough that the input backs up
  task automatic test_output_hold();
    hold_requests++;
    for (int i = 0; i < 40; i++)
      send_cmd(ACT_READ, $urandom_range(31), $urandom_range(31), 0, 0);
    drain();
  endtask

  task automatic test_random_mazes();
    int sent, phase, sz, sd, pick, reads;
    sent = 0;
    phase = 0;
    while (sent < 1000) begin
      quiet = (phase >= 6 && phase < 12);
      pick = $urandom_range(99);
      if (pick < 80) sz = $urandom_range(3, 8);
      else if (pick < 90) sz = $urandom_range(9, 16);
      else if (pick < 95) sz = $urandom_range(0, 63);
      else sz = 32;
      sd = (sz > GRID) ? GRID : sz;
      if (sd > 0 && $urandom_range(9) != 0)
        set_maze(sz, $urandom_range(sd - 1), $urandom_range(sd - 1),
                 $urandom_range(sd - 1), $urandom_range(sd - 1));
      else
        set_maze(sz, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                 $urandom_range(31));
      // Lay out the maze: every cell of small grids, a scatter on big ones
      if (sd <= 8) begin
        for (int x = 0; x < sd; x++)
          for (int y = 0; y < sd; y++) begin
            send_cmd(ACT_WRITE, x, y, $urandom_range(99) < 72, 0);
            sent++;
          end
      end else begin
        for (int i = 0; i < 40; i++) begin
          send_cmd(ACT_WRITE, $urandom_range(sd - 1), $urandom_range(sd - 1),
                   $urandom_range(99) < 80, 0);
          sent++;
        end
      end
      if ($urandom_range(99) < 85) begin
        send_cmd(ACT_WRITE, start_x_reg, start_y_reg, 1, 0);
        send_cmd(ACT_WRITE, goal_x_reg, goal_y_reg, 1, 0);
        sent += 2;
      end
      send_cmd(ACT_SOLVE, 0, 0, 0, 0);
      reads = $urandom_range(3, 10);
      for (int i = 0; i < reads; i++) begin
        if ($urandom_range(99) < 80) send_cmd(ACT_ROUTE, 0, 0, 0, $urandom_range(path_depth));
        else send_cmd(ACT_ROUTE, 0, 0, 0, $urandom_range(1023));
        send_cmd(ACT_READ, $urandom_range(31), $urandom_range(31), 0, 0);
      end
      if ($urandom_range(99) < 30) send_cmd(ACT_SOLVE, 0, 0, 0, 0);
      // Noise anywhere in the coordinate range
      for (int i = 0; i < 3; i++)
        send_cmd(ACT_WRITE, $urandom_range(31), $urandom_range(31), $urandom_range(1), 0);
      sent += 2 * reads + 5;
      phase++;
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < CELLS; i++) grid_mem[i] = pack_cell(ST_WALL, D_NONE, D_NONE);
    for (int i = 0; i < CELLS; i++) path_mem[i] = '0;
    path_depth = 0;
    size_reg = SIZE_RESET;
    start_x_reg = 1;
    start_y_reg = 1;
    goal_x_reg = 1;
    goal_y_reg = 1;
    test_reset_defaults();
    test_small_grid();
    test_full_grid();
    test_output_hold();
    test_random_mazes();
    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("maze_path_search_test: done, clean");
    else $display("maze_path_search_test: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mps_pkg.sv
hw/rtl/maze_path_search.sv
verif/maze_path_search_test.sv
